// ----- hdl/saes_pkg.sv -----
// Shared types, tables and round functions of the 16-bit simplified AES cipher.
package saes_pkg;

	localparam int BLK_W = 16;
	localparam int KEY_W = 16;

	localparam logic [7:0] RCON_1 = 8'h80;
	localparam logic [7:0] RCON_2 = 8'h30;

	localparam logic [3:0] MIX_ENC_A = 4'h1;
	localparam logic [3:0] MIX_ENC_B = 4'h4;
	localparam logic [3:0] MIX_DEC_A = 4'h9;
	localparam logic [3:0] MIX_DEC_B = 4'h2;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef struct packed {
		logic [BLK_W-1:0] k0;
		logic [BLK_W-1:0] k1;
		logic [BLK_W-1:0] k2;
	} round_keys_t;

	function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
		logic [3:0] r;
		case (n)
			4'h0: r = 4'h9;
			4'h1: r = 4'h4;
			4'h2: r = 4'hA;
			4'h3: r = 4'hB;
			4'h4: r = 4'hD;
			4'h5: r = 4'h1;
			4'h6: r = 4'h8;
			4'h7: r = 4'h5;
			4'h8: r = 4'h6;
			4'h9: r = 4'h2;
			4'hA: r = 4'h0;
			4'hB: r = 4'h3;
			4'hC: r = 4'hC;
			4'hD: r = 4'hE;
			4'hE: r = 4'hF;
			4'hF: r = 4'h7;
			default: r = 4'h0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] sbox_inv(input logic [3:0] n);
		logic [3:0] r;
		case (n)
			4'h0: r = 4'hA;
			4'h1: r = 4'h5;
			4'h2: r = 4'h9;
			4'h3: r = 4'hB;
			4'h4: r = 4'h1;
			4'h5: r = 4'h7;
			4'h6: r = 4'h8;
			4'h7: r = 4'hF;
			4'h8: r = 4'h6;
			4'h9: r = 4'h0;
			4'hA: r = 4'h2;
			4'hB: r = 4'h3;
			4'hC: r = 4'hC;
			4'hD: r = 4'h4;
			4'hE: r = 4'hD;
			4'hF: r = 4'hE;
			default: r = 4'h0;
		endcase
		return r;
	endfunction

	// GF(16) product, modulus x^4 + x + 1
	function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
		logic [3:0] r;
		logic [3:0] x;
		r = 4'h0;
		x = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) begin
				r = r ^ x;
			end
			x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
		end
		return r;
	endfunction

	function automatic logic [BLK_W-1:0] sub_fwd(input logic [BLK_W-1:0] x);
		return {sbox_fwd(x[15:12]), sbox_fwd(x[11:8]), sbox_fwd(x[7:4]), sbox_fwd(x[3:0])};
	endfunction

	function automatic logic [BLK_W-1:0] sub_inv(input logic [BLK_W-1:0] x);
		return {sbox_inv(x[15:12]), sbox_inv(x[11:8]), sbox_inv(x[7:4]), sbox_inv(x[3:0])};
	endfunction

	// swap nibble 1 and nibble 3
	function automatic logic [BLK_W-1:0] shift_rows(input logic [BLK_W-1:0] x);
		return {x[15:12], x[3:0], x[7:4], x[11:8]};
	endfunction

	function automatic logic [BLK_W-1:0] mix_block(input logic [BLK_W-1:0] x,
			input logic [3:0] a, input logic [3:0] b);
		logic [3:0] m0, m1, m2, m3;
		m0 = gf16_mul(a, x[15:12]) ^ gf16_mul(b, x[11:8]);
		m1 = gf16_mul(b, x[15:12]) ^ gf16_mul(a, x[11:8]);
		m2 = gf16_mul(a, x[7:4]) ^ gf16_mul(b, x[3:0]);
		m3 = gf16_mul(b, x[7:4]) ^ gf16_mul(a, x[3:0]);
		return {m0, m1, m2, m3};
	endfunction

	// rotate nibbles, substitute, add round constant
	function automatic logic [7:0] key_g(input logic [7:0] w, input logic [7:0] rcon);
		return {sbox_fwd(w[3:0]), sbox_fwd(w[7:4])} ^ rcon;
	endfunction

	function automatic round_keys_t expand_key(input logic [KEY_W-1:0] key);
		round_keys_t rk;
		logic [7:0] w2, w3, w4, w5;
		w2 = key[15:8] ^ key_g(key[7:0], RCON_1);
		w3 = w2 ^ key[7:0];
		w4 = w2 ^ key_g(w3, RCON_2);
		w5 = w4 ^ w3;
		rk.k0 = key;
		rk.k1 = {w2, w3};
		rk.k2 = {w4, w5};
		return rk;
	endfunction

	function automatic logic [BLK_W-1:0] encrypt_block(input logic [BLK_W-1:0] x,
			input round_keys_t rk);
		logic [BLK_W-1:0] s;
		s = x ^ rk.k0;
		s = shift_rows(sub_fwd(s));
		s = mix_block(s, MIX_ENC_A, MIX_ENC_B) ^ rk.k1;
		s = shift_rows(sub_fwd(s)) ^ rk.k2;
		return s;
	endfunction

	function automatic logic [BLK_W-1:0] decrypt_block(input logic [BLK_W-1:0] x,
			input round_keys_t rk);
		logic [BLK_W-1:0] s;
		s = x ^ rk.k2;
		s = sub_inv(shift_rows(s)) ^ rk.k1;
		s = mix_block(s, MIX_DEC_A, MIX_DEC_B);
		s = sub_inv(shift_rows(s)) ^ rk.k0;
		return s;
	endfunction

endpackage

// ----- hdl/simplified_aes_cipher.sv -----
// Top level of the 16-bit simplified AES cipher with stream ports.
//
// Each request on the slave side carries one 16-bit block in s_axis_tdata and the
// direction in s_axis_tuser (0 encrypt, 1 decrypt); one 16-bit result block leaves
// on the master side per request, in order. A request is registered, both rounds are
// computed combinationally from that register into the result register, which drives
// m_axis_tvalid, and a new request is taken every cycle while the master side keeps
// up. The cipher key is written through key_wr_en and key_wr_data, reads 0 after
// reset, and must only change while no request is in flight.
module simplified_aes_cipher import saes_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_wr_en,
	input  logic [KEY_W-1:0] key_wr_data,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [BLK_W-1:0] s_axis_tdata,  // [15:0] data_in
	input  logic             s_axis_tuser,  // [0] op
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [BLK_W-1:0] m_axis_tdata   // [15:0] data_out
);

	round_keys_t      rk;
	logic             valid_s1;
	op_t              op_s1;
	logic [BLK_W-1:0] data_s1;
	logic             valid_s2;
	logic [BLK_W-1:0] data_s2;
	logic             s2_free;
	logic             s1_adv;
	logic [BLK_W-1:0] result;

	saes_keyexp u_keyexp (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_wr_en   (key_wr_en),
		.key_wr_data (key_wr_data),
		.rk          (rk)
	);

	assign s2_free       = !valid_s2 || m_axis_tready;
	assign s1_adv        = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;

	always_comb begin
		case (op_s1)
			OP_ENCRYPT: result = encrypt_block(data_s1, rk);
			OP_DECRYPT: result = decrypt_block(data_s1, rk);
			default:    result = encrypt_block(data_s1, rk);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= op_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata;
		end
		if (s1_adv) begin
			data_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> valid_s2)
		else $error("advanced request did not reach result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while both stages are stalled");

	a_enc_roundtrip: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && op_s1 == OP_ENCRYPT |=>
		decrypt_block(data_s2, $past(rk)) == $past(data_s1))
		else $error("encryption does not invert");

	a_dec_roundtrip: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && op_s1 == OP_DECRYPT |=>
		encrypt_block(data_s2, $past(rk)) == $past(data_s1))
		else $error("decryption does not invert");

endmodule

// ----- hdl/saes_keyexp.sv -----
// Cipher key register and expansion into the three round keys.
module saes_keyexp import saes_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_wr_en,
	input  logic [KEY_W-1:0] key_wr_data,
	output round_keys_t      rk
);

	logic [KEY_W-1:0] key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (key_wr_en) begin
			key_q <= key_wr_data;
		end
	end

	assign rk = expand_key(key_q);

endmodule
